### rtl/serial_lcd_reply_parser_assert.svh
// Assertion macros for the serial display reply parser checker.
// Depends on nothing; included by the checker file only.
`ifndef SERIAL_LCD_REPLY_PARSER_ASSERT_SVH
`define SERIAL_LCD_REPLY_PARSER_ASSERT_SVH

// Assertion that is switched off while reset is held.
`define SLRP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Assertion that is checked during reset as well.
`define SLRP_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/slrp_pkg.sv
// Shared types and constants for the serial display reply parser.
// Depends on nothing; imported by every module of the block.
package slrp_pkg;

    // Sentence store geometry
    localparam int SENTENCE_BYTES = 32;
    localparam int SB_W           = $clog2(SENTENCE_BYTES);
    localparam int PTR_W          = SB_W + 1;
    localparam int LEVEL_POS      = 5;

    // Byte queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_W     = $clog2(QUEUE_DEPTH);

    // Character codes
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_XON    = 8'h11;
    localparam logic [7:0] CH_XOFF   = 8'h13;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Numeric limits
    localparam logic [7:0]  FRAME_RESET = 8'd13;
    localparam logic [15:0] MAG_LIMIT   = 16'hFFFF;
    localparam logic [15:0] IDX_LIMIT   = 16'd255;
    localparam logic [7:0]  DIV10_MUL   = 8'd205;
    localparam int          DIV10_SHIFT = 11;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_MOMENT = 3'd1,
        EV_SLIDER = 3'd2,
        EV_LATCH  = 3'd3,
        EV_BAD    = 3'd4,
        EV_ERROR  = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } t_back_state;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_BLANK,
        PH_DIGIT
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       is_frame;
    } t_slot;

    typedef struct packed {
        logic  push;
        t_slot slot;
    } t_q_wr;

    typedef struct packed {
        logic  avail;
        t_slot slot;
    } t_q_rd;

endpackage

### rtl/serial_lcd_reply_parser.sv
// Top level of the serial display reply parser.
// Depends on slrp_pkg, slrp_front, slrp_queue and slrp_back.
//
// Usage:
//   Received words enter on i_rx_byte through a queue-style port: a word is
//   taken when push is high and full is low. Results leave the same way:
//   while empty is low the oldest result sits on the o_* ports and is taken
//   when pop is high. i_frame_char is written over the cfg valid/ready
//   channel (ready is always high) and should change only while idle.
//   A four-word queue sits between the front and the back, so bytes keep
//   coming in while a sentence is decoded or a result waits to be popped.
//   An ordinary word is stored in the back end. A frame word starts a walk
//   over the 32-byte store, one byte per cycle through the registered read
//   port; the walk scans at most 33 positions, and for a slider it restarts
//   at the level position, its two scans covering at most 61 positions.
//   When pop stays low, the result is held and the back stops after the
//   next sentence; the queue then fills and full rises.
//   Synchronous reset clears the store valid bits, fill count, pause flag,
//   error count, word queue and result valid flag; frame_char returns to CR.
module serial_lcd_reply_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_frame_char,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_button_index,
    output logic [15:0] o_button_state,
    output logic        o_flow_paused,
    output logic [15:0] o_error_count
);
    import slrp_pkg::*;

    t_q_wr q_wr;
    t_q_rd q_rd;
    logic  q_full;
    logic  q_take;
    t_kind back_kind;

    slrp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_frame_char (i_frame_char),
        .i_push       (push),
        .o_full       (full),
        .i_rx_byte    (i_rx_byte),
        .i_q_full     (q_full),
        .o_wr         (q_wr)
    );

    slrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .o_rd    (q_rd),
        .i_take  (q_take)
    );

    slrp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rd           (q_rd),
        .o_take         (q_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_event_kind   (back_kind),
        .o_button_index (o_button_index),
        .o_button_state (o_button_state),
        .o_flow_paused  (o_flow_paused),
        .o_error_count  (o_error_count)
    );

    assign o_event_kind = back_kind;

endmodule

### rtl/slrp_queue.sv
// Short queue of classified words between the front and the back.
// Depends on slrp_pkg for the slot and handshake structs.
module slrp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  slrp_pkg::t_q_wr i_wr,
    output logic            o_full,
    output slrp_pkg::t_q_rd o_rd,
    input  logic            i_take
);
    import slrp_pkg::*;

    t_slot                r_slots [QUEUE_DEPTH];
    logic [QUEUE_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_W:0]     r_count,  n_count;
    logic                 do_wr, do_rd;

    // Qualify both sides against the fill level
    always_comb begin
        do_wr    = i_wr.push && (r_count != (QUEUE_W+1)'(QUEUE_DEPTH));
        do_rd    = i_take && (r_count != '0);
        n_wr_ptr = do_wr ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_rd ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (QUEUE_W+1)'(do_wr) - (QUEUE_W+1)'(do_rd);
    end

    assign o_full     = (r_count == (QUEUE_W+1)'(QUEUE_DEPTH));
    assign o_rd.avail = (r_count != '0);
    assign o_rd.slot  = r_slots[r_rd_ptr];

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_slots[r_wr_ptr] <= i_wr.slot;
        end
    end

endmodule

### rtl/slrp_front.sv
// Front end: holds the frame character and tags each received word.
// Depends on slrp_pkg for the queue write struct.
module slrp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [7:0]      i_frame_char,
    input  logic            i_push,
    output logic            o_full,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_q_full,
    output slrp_pkg::t_q_wr o_wr
);
    import slrp_pkg::*;

    logic [7:0] r_frame_char, n_frame_char;

    // Take a configuration write at any time
    always_comb begin
        n_frame_char = i_cfg_valid ? i_frame_char : r_frame_char;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_char <= FRAME_RESET;
        end else begin
            r_frame_char <= n_frame_char;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_full      = i_q_full;

    // Tag a frame-character word as a sentence end; push while the queue has room
    always_comb begin
        o_wr.push          = i_push && !i_q_full;
        o_wr.slot.data     = i_rx_byte;
        o_wr.slot.is_frame = (i_rx_byte == r_frame_char);
    end

endmodule

### rtl/slrp_back.sv
// Back end: sentence store, number reader walk and result register.
// Depends on slrp_pkg for constants, state enums and queue structs.
module slrp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  slrp_pkg::t_q_rd i_rd,
    output logic            o_take,
    input  logic            i_pop,
    output logic            o_empty,
    output slrp_pkg::t_kind o_event_kind,
    output logic [7:0]      o_button_index,
    output logic [15:0]     o_button_state,
    output logic            o_flow_paused,
    output logic [15:0]     o_error_count
);
    import slrp_pkg::*;

    // Sentence store with a valid bit per entry
    logic [7:0]                r_mem [SENTENCE_BYTES];
    logic [SENTENCE_BYTES-1:0] r_valid, n_valid;
    logic [SB_W-1:0]           r_fill, n_fill, fill_wrap;

    // Walk control
    t_back_state r_state, n_state;
    t_phase      r_phase, n_phase;
    logic        r_second, n_second;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic        r_rd_ok, n_rd_ok;
    logic [7:0]  r_rd_data;
    logic        r_rd_hit;
    logic        rd_hit_c;
    logic [SB_W-1:0] rd_idx;
    logic        wr_en, rd_en;

    // Decode working registers
    logic [7:0]  r_head, n_head;
    logic [15:0] r_mag,  n_mag;
    logic        r_neg,  n_neg;
    t_kind       r_kind, n_kind;
    logic [7:0]  r_idx,  n_idx;
    logic [15:0] r_st,   n_st;
    logic        r_pause, n_pause;
    logic [15:0] r_tally, n_tally;

    // Result register
    logic        r_ovalid, n_ovalid;
    t_kind       r_o_kind, n_o_kind;
    logic [7:0]  r_o_idx, n_o_idx;
    logic [15:0] r_o_st, n_o_st;
    logic        r_o_pause, n_o_pause;
    logic [15:0] r_o_tally, n_o_tally;
    logic        load_out;

    // Datapath helpers
    logic [7:0]  c;
    logic        is_blank, is_digit, is_sign, finish, bad;
    logic [3:0]  digit;
    logic [19:0] mag_x10;
    logic [15:0] mag_acc;
    logic [15:0] q_prod;
    logic [7:0]  idx_x10;
    logic [7:0]  latch_st;

    assign c        = r_rd_hit ? r_rd_data : 8'd0;
    assign is_blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
    assign digit    = 4'(c - CH_ZERO);
    assign mag_x10  = ({4'd0, r_mag} << 3) + ({4'd0, r_mag} << 1) + {16'd0, digit};
    assign mag_acc  = (mag_x10 > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : mag_x10[15:0];
    assign bad      = (r_mag > IDX_LIMIT) || (r_neg && r_mag != 16'd0);
    assign q_prod   = {8'd0, r_mag[7:0]} * {8'd0, DIV10_MUL};
    assign idx_x10  = (r_idx << 3) + (r_idx << 1);
    assign latch_st = r_mag[7:0] - idx_x10;
    assign fill_wrap = (r_fill == SB_W'(SENTENCE_BYTES - 1)) ? '0 : r_fill + 1'b1;
    assign rd_idx   = r_ptr[SB_W-1:0];
    assign rd_hit_c = (r_ptr < PTR_W'(SENTENCE_BYTES)) && r_valid[rd_idx];

    // Next state, walk and result logic
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_second  = r_second;
        n_ptr     = r_ptr;
        n_rd_ok   = r_rd_ok;
        n_fill    = r_fill;
        n_valid   = r_valid;
        n_head    = r_head;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_kind    = r_kind;
        n_idx     = r_idx;
        n_st      = r_st;
        n_pause   = r_pause;
        n_tally   = r_tally;
        n_ovalid  = r_ovalid && !i_pop;
        n_o_kind  = r_o_kind;
        n_o_idx   = r_o_idx;
        n_o_st    = r_o_st;
        n_o_pause = r_o_pause;
        n_o_tally = r_o_tally;
        o_take    = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        finish    = 1'b0;
        load_out  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // Store one word; a sentence end starts the walk
                if (i_rd.avail) begin
                    o_take           = 1'b1;
                    wr_en            = 1'b1;
                    n_valid[r_fill]  = 1'b1;
                    n_fill           = fill_wrap;
                    if (i_rd.slot.is_frame) begin
                        n_valid[fill_wrap]          = 1'b0;
                        n_valid[SENTENCE_BYTES-1]   = 1'b0;
                        n_fill   = '0;
                        n_state  = S_WALK;
                        n_ptr    = '0;
                        n_rd_ok  = 1'b0;
                        n_phase  = PH_HEAD;
                        n_second = 1'b0;
                    end
                end
            end
            S_WALK: begin
                rd_en   = 1'b1;
                n_ptr   = r_ptr + 1'b1;
                n_rd_ok = 1'b1;
                if (r_rd_ok) begin
                    unique case (r_phase)
                        PH_HEAD: begin
                            n_head = c;
                            n_mag  = '0;
                            n_neg  = 1'b0;
                            if (c == CH_X || c == CH_L || c == CH_S) begin
                                n_phase = PH_BLANK;
                            end else begin
                                n_kind  = (c == CH_BANG || c == CH_CARET || c == CH_QUEST)
                                          ? EV_ERROR : EV_NONE;
                                n_idx   = '0;
                                n_st    = '0;
                                n_state = S_EMIT;
                            end
                        end
                        PH_BLANK: begin
                            priority if (is_blank) begin
                                n_phase = PH_BLANK;
                            end else if (is_sign) begin
                                n_neg   = (c == CH_MINUS);
                                n_phase = PH_DIGIT;
                            end else if (is_digit) begin
                                n_mag   = mag_acc;
                                n_phase = PH_DIGIT;
                            end else begin
                                finish = 1'b1;
                            end
                        end
                        PH_DIGIT: begin
                            if (is_digit) begin
                                n_mag = mag_acc;
                            end else begin
                                finish = 1'b1;
                            end
                        end
                        default: begin
                            n_phase = PH_HEAD;
                        end
                    endcase
                end

                // Number complete: settle the result or restart for the level
                if (finish) begin
                    priority if (r_second) begin
                        n_st    = r_neg ? 16'd0 : r_mag;
                        n_state = S_EMIT;
                    end else if (bad) begin
                        n_kind  = EV_BAD;
                        n_idx   = '0;
                        n_st    = '0;
                        n_state = S_EMIT;
                    end else if (r_head == CH_X) begin
                        n_kind  = EV_MOMENT;
                        n_idx   = r_mag[7:0];
                        n_st    = '0;
                        n_state = S_EMIT;
                    end else if (r_head == CH_L) begin
                        n_kind   = EV_SLIDER;
                        n_idx    = r_mag[7:0];
                        n_second = 1'b1;
                        n_ptr    = PTR_W'(LEVEL_POS);
                        n_rd_ok  = 1'b0;
                        n_phase  = PH_BLANK;
                        n_mag    = '0;
                        n_neg    = 1'b0;
                    end else begin
                        n_kind  = EV_LATCH;
                        n_idx   = 8'(q_prod[15:DIV10_SHIFT]);
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                // Commit flags and load the result once the register frees up
                if (!r_ovalid || i_pop) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                    if (r_head == CH_XON) begin
                        n_pause = 1'b0;
                    end else if (r_head == CH_XOFF) begin
                        n_pause = 1'b1;
                    end
                    if (r_kind == EV_ERROR && r_tally != MAG_LIMIT) begin
                        n_tally = r_tally + 1'b1;
                    end
                    n_ovalid  = 1'b1;
                    n_o_kind  = r_kind;
                    n_o_idx   = r_idx;
                    n_o_st    = (r_kind == EV_LATCH) ? {8'd0, latch_st} : r_st;
                    n_o_pause = n_pause;
                    n_o_tally = n_tally;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_HEAD;
            r_second <= 1'b0;
            r_ptr    <= '0;
            r_rd_ok  <= 1'b0;
            r_fill   <= '0;
            r_valid  <= '0;
            r_pause  <= 1'b0;
            r_tally  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_second <= n_second;
            r_ptr    <= n_ptr;
            r_rd_ok  <= n_rd_ok;
            r_fill   <= n_fill;
            r_valid  <= n_valid;
            r_pause  <= n_pause;
            r_tally  <= n_tally;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_kind <= n_kind;
        r_idx  <= n_idx;
        r_st   <= n_st;
        if (load_out) begin
            r_o_kind  <= n_o_kind;
            r_o_idx   <= n_o_idx;
            r_o_st    <= n_o_st;
            r_o_pause <= n_o_pause;
            r_o_tally <= n_o_tally;
        end
    end

    // Sentence store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_fill] <= i_rd.slot.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_idx];
            r_rd_hit  <= rd_hit_c;
        end
    end

    assign o_empty        = !r_ovalid;
    assign o_event_kind   = r_o_kind;
    assign o_button_index = r_o_idx;
    assign o_button_state = r_o_st;
    assign o_flow_paused  = r_o_pause;
    assign o_error_count  = r_o_tally;

endmodule

### rtl/slrp_checker.sv
// Port-level checker for the serial display reply parser, bound to the top.
// Depends on slrp_pkg and serial_lcd_reply_parser_assert.svh.
`include "serial_lcd_reply_parser_assert.svh"

module slrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  o_event_kind,
    input logic [7:0]  o_button_index,
    input logic [15:0] o_button_state,
    input logic [15:0] o_error_count
);
    import slrp_pkg::*;

    // Result side comes up empty out of reset
    `SLRP_ASSERT_ANY(a_reset_empty, i_clk, !i_rst_n |=> empty, "result waiting after reset")

    // Hold a stalled result
    `SLRP_ASSERT_RST(a_stall_hold, i_clk, i_rst_n,
        (!empty && !pop) |=> (!empty && $stable(o_event_kind) && $stable(o_error_count)),
        "stalled result changed")

    // Kinds without a button carry zero index and state
    `SLRP_ASSERT_RST(a_idle_fields, i_clk, i_rst_n,
        (!empty && (o_event_kind == EV_NONE || o_event_kind == EV_BAD ||
                    o_event_kind == EV_ERROR))
            |-> (o_button_index == 8'd0 && o_button_state == 16'd0),
        "stray index or state")

    // Latching results split a number below 256 into tens and units
    `SLRP_ASSERT_RST(a_latch_range, i_clk, i_rst_n,
        (!empty && o_event_kind == EV_LATCH)
            |-> (o_button_state <= 16'd9 && o_button_index <= 8'd25),
        "latch split out of range")

    // Error count never drops between shown results
    `SLRP_ASSERT_RST(a_errcnt_mono, i_clk, i_rst_n,
        (!empty && $past(!empty) && $past(i_rst_n))
            |-> (o_error_count >= $past(o_error_count)),
        "error count dropped")

endmodule

bind serial_lcd_reply_parser slrp_checker u_slrp_checker (.*);
